>>> rtl/core/crc_xor_packet_framer_unit_defines.svh
// ----------------------------------------------------------------------------
// crc_xor_packet_framer_unit_defines
// Assertion macros shared by the packet framer RTL.
// ----------------------------------------------------------------------------
`ifndef CRC_XOR_PACKET_FRAMER_UNIT_DEFINES_SVH
`define CRC_XOR_PACKET_FRAMER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CRCXF_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer check failed");

// next-cycle implication, checked out of reset
`define CRCXF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer check failed");

// delayed implication, checked out of reset
`define CRCXF_ASSERT_LATER(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("framer check failed");

`endif

>>> rtl/core/crcxf_pkg.sv
// ----------------------------------------------------------------------------
// crcxf_pkg
// Types, constants and helper functions of the CRC / XOR packet framer.
// ----------------------------------------------------------------------------
package crcxf_pkg;

    // default depth of the front-to-back command queue
    localparam int CRCXF_QUEUE_DEPTH = 4;

    // crc-32, reflected form
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // scrambler position counters
    localparam logic [4:0] PHASE_MOD = 5'd24;
    localparam logic [7:0] RAMP_STEP = 8'd31;

    // configuration register indexes
    localparam int          CFG_INDEX_W    = 2;
    localparam logic [1:0]  REG_CRC_ENABLE = 2'd0;
    localparam logic [1:0]  REG_XOR_ENABLE = 2'd1;
    localparam logic [1:0]  REG_XOR_KEY    = 2'd2;

    // output steps of one command: header, body byte, suffix
    localparam int          STEP_W         = 5;
    localparam logic [4:0]  STEP_HDR_FIRST = 5'd0;
    localparam logic [4:0]  STEP_HDR_HEX   = 5'd6;
    localparam logic [4:0]  STEP_HDR_SEMI  = 5'd14;
    localparam logic [4:0]  STEP_BODY      = 5'd15;
    localparam logic [4:0]  STEP_TAIL_TEXT = 5'd16;
    localparam logic [4:0]  STEP_TAIL_HEX  = 5'd21;
    localparam logic [4:0]  STEP_LAST      = 5'd28;

    // "NONCE=" and "|CRC=" text
    localparam logic [7:0] NONCE_TEXT [6] = '{8'h4E, 8'h4F, 8'h4E, 8'h43, 8'h45, 8'h3D};
    localparam logic [7:0] TAIL_TEXT  [5] = '{8'h7C, 8'h43, 8'h52, 8'h43, 8'h3D};
    localparam logic [7:0] CHAR_SEMI      = 8'h3B;

    // configuration seen by the front end
    typedef struct packed {
        logic       crc_enable;
        logic       xor_enable;
        logic [7:0] xor_key;
    } cfg_t;

    // one command from front to back
    typedef struct packed {
        logic        hdr;      // first byte of a packet: send header first
        logic [31:0] nonce;
        logic [7:0]  body;     // already scrambled body byte
        logic        last;
        logic        tail;     // append crc suffix
        logic [31:0] crc;      // final (inverted) crc of the packet
        logic [4:0]  phase;    // scramble position of the body byte
        logic [7:0]  ramp;
        logic        scr_en;
        logic [7:0]  key;
    } entry_t;

    // one byte through the reflected crc-32
    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // ascii hex digit, lower or upper case
    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        if (nib < 4'd10) begin
            base = 8'h30;
        end
        else begin
            base = upper ? 8'h37 : 8'h57;
        end
        return base + {4'd0, nib};
    endfunction

    // rolling key byte at one position
    function automatic logic [7:0] scramble_key(input logic [7:0] key, input logic [31:0] nonce,
                                                input logic [4:0] phase, input logic [7:0] ramp);
        logic [31:0] sh;
        sh = nonce >> phase;
        return key ^ sh[7:0] ^ ramp;
    endfunction

    // header character at a header step
    function automatic logic [7:0] header_char(input logic [4:0] step, input logic [31:0] nonce);
        logic [2:0] nib_sel;
        logic [7:0] ch;
        nib_sel = 3'(STEP_HDR_SEMI - 5'd1 - step);
        if (step < STEP_HDR_HEX) begin
            ch = NONCE_TEXT[step[2:0]];
        end
        else if (step < STEP_HDR_SEMI) begin
            ch = hex_char(nonce[{nib_sel, 2'b00} +: 4], 1'b0);
        end
        else begin
            ch = CHAR_SEMI;
        end
        return ch;
    endfunction

    // plain suffix character at a suffix step
    function automatic logic [7:0] tail_char(input logic [4:0] step, input logic [31:0] crc);
        logic [2:0] nib_sel;
        logic [2:0] txt_sel;
        logic [7:0] ch;
        nib_sel = 3'(STEP_LAST - step);
        txt_sel = 3'(step - STEP_TAIL_TEXT);
        if (step < STEP_TAIL_HEX) begin
            ch = TAIL_TEXT[txt_sel];
        end
        else begin
            ch = hex_char(crc[{nib_sel, 2'b00} +: 4], 1'b1);
        end
        return ch;
    endfunction

endpackage

>>> rtl/core/crcxf_front.sv
// ----------------------------------------------------------------------------
// crcxf_front
// Accepts body bytes, runs the crc and packet state, builds one command each.
// ----------------------------------------------------------------------------
module crcxf_front
    import crcxf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  cfg_t       cfg,
    output logic       q_push,
    output entry_t     q_entry
);

    logic [31:0] crc_reg,    crc_next;
    logic [31:0] nonce_reg,  nonce_next;
    logic [4:0]  phase_reg,  phase_next;
    logic [7:0]  ramp_reg,   ramp_next;
    logic        inpkt_reg,  inpkt_next;

    logic [31:0] crc_upd;
    logic        scr_en;
    logic [7:0]  body_key;

    // crc and body scrambling for the beat on the input
    always_comb
    begin
        crc_upd  = crc_update(crc_reg, data_byte);
        scr_en   = cfg.xor_enable && (cfg.xor_key != 8'd0);
        body_key = scramble_key(cfg.xor_key, nonce_reg, phase_reg, ramp_reg);
    end

    // command for the back end
    always_comb
    begin
        q_push         = accept;
        q_entry.hdr    = !inpkt_reg;
        q_entry.nonce  = nonce_reg;
        q_entry.body   = scr_en ? (data_byte ^ body_key) : data_byte;
        q_entry.last   = last_byte;
        q_entry.tail   = last_byte && cfg.crc_enable;
        q_entry.crc    = ~crc_upd;
        q_entry.phase  = phase_reg;
        q_entry.ramp   = ramp_reg;
        q_entry.scr_en = scr_en;
        q_entry.key    = cfg.xor_key;
    end

    // packet state: close on last byte, else advance position
    always_comb
    begin
        crc_next   = crc_reg;
        nonce_next = nonce_reg;
        phase_next = phase_reg;
        ramp_next  = ramp_reg;
        inpkt_next = inpkt_reg;
        if (accept) begin
            if (last_byte) begin
                crc_next   = CRC_INIT;
                nonce_next = nonce_reg + 32'd1;
                phase_next = '0;
                ramp_next  = '0;
                inpkt_next = 1'b0;
            end
            else begin
                crc_next   = crc_upd;
                phase_next = (phase_reg == PHASE_MOD - 5'd1) ? 5'd0 : phase_reg + 5'd1;
                ramp_next  = ramp_reg + RAMP_STEP;
                inpkt_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg   <= CRC_INIT;
            nonce_reg <= '0;
            phase_reg <= '0;
            ramp_reg  <= '0;
            inpkt_reg <= 1'b0;
        end
        else begin
            crc_reg   <= crc_next;
            nonce_reg <= nonce_next;
            phase_reg <= phase_next;
            ramp_reg  <= ramp_next;
            inpkt_reg <= inpkt_next;
        end
    end

endmodule

>>> rtl/core/crcxf_queue.sv
// ----------------------------------------------------------------------------
// crcxf_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module crcxf_queue
    import crcxf_pkg::*;
#(
    parameter int DEPTH = CRCXF_QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          slots [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg,    cnt_next;

    // status and head
    assign full       = (cnt_reg == CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = slots[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/core/crcxf_back.sv
// ----------------------------------------------------------------------------
// crcxf_back
// Expands each command into header, body and suffix beats on the output.
// ----------------------------------------------------------------------------
module crcxf_back
    import crcxf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  entry_t     head_entry,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic              started_reg, started_next;
    logic [STEP_W-1:0] step_reg,    step_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;

    logic [STEP_W-1:0] cur_step;
    logic [3:0]        tail_off;
    logic [5:0]        phase_sum;
    logic [4:0]        tail_phase;
    logic [7:0]        tail_ramp;
    logic [7:0]        tail_plain;
    logic [7:0]        tail_key;
    logic [7:0]        beat_byte;
    logic              beat_last;
    logic              done;
    logic              advance;

    // step of the head command
    always_comb
    begin
        if (started_reg) begin
            cur_step = step_reg;
        end
        else begin
            cur_step = head_entry.hdr ? STEP_HDR_FIRST : STEP_BODY;
        end
    end

    // suffix position: body position plus offset, wrapped
    always_comb
    begin
        tail_off   = 4'(cur_step - STEP_BODY);
        phase_sum  = {1'b0, head_entry.phase} + {2'b00, tail_off};
        tail_phase = (phase_sum >= {1'b0, PHASE_MOD}) ? 5'(phase_sum - {1'b0, PHASE_MOD})
                                                      : phase_sum[4:0];
        tail_ramp  = head_entry.ramp + 8'({4'd0, tail_off} * RAMP_STEP);
        tail_plain = tail_char(cur_step, head_entry.crc);
        tail_key   = scramble_key(head_entry.key, head_entry.nonce, tail_phase, tail_ramp);
    end

    // beat selection
    always_comb
    begin
        if (cur_step < STEP_BODY) begin
            beat_byte = header_char(cur_step, head_entry.nonce);
            beat_last = 1'b0;
        end
        else if (cur_step == STEP_BODY) begin
            beat_byte = head_entry.body;
            beat_last = head_entry.last && !head_entry.tail;
        end
        else begin
            beat_byte = head_entry.scr_en ? (tail_plain ^ tail_key) : tail_plain;
            beat_last = (cur_step == STEP_LAST);
        end
        done = ((cur_step == STEP_BODY) && !head_entry.tail) || (cur_step == STEP_LAST);
    end

    // sequencing
    always_comb
    begin
        advance        = head_valid && (!out_valid_reg || pop);
        q_pop          = advance && done;
        started_next   = started_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !pop;
        if (advance) begin
            out_valid_next = 1'b1;
            started_next   = !done;
            step_next      = cur_step + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            started_reg   <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            started_reg   <= started_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_byte_reg <= beat_byte;
            out_last_reg <= beat_last;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign out_last = out_last_reg;

endmodule

>>> rtl/core/crc_xor_packet_framer_unit.sv
// ----------------------------------------------------------------------------
// crc_xor_packet_framer_unit
// Frames body bytes into text packets with nonce header and crc-32 suffix.
// ----------------------------------------------------------------------------
// Each packet opens with the unscrambled header "NONCE=<8 lowercase hex>;",
// then its body bytes, then on the last byte (when crc_enable is set) the
// suffix "|CRC=<8 uppercase hex>". Body and suffix are XOR-scrambled when
// xor_enable is set and xor_key is nonzero. The back end emits one output
// beat per cycle unless pop stalls it: a body byte, with the header before
// the first byte of a packet and the suffix after a last byte with suffix.
// The front end takes one byte per cycle while the command queue has room,
// so input runs ahead of a header or suffix by up to the queue depth. Input
// beats are registered in the queue, then the output register. The user
// must write configuration only while idle; the block does not enforce it.
`include "crc_xor_packet_framer_unit_defines.svh"

module crc_xor_packet_framer_unit
    import crcxf_pkg::*;
#(
    parameter int QUEUE_DEPTH = CRCXF_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input queue side
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    // result queue side
    output logic                   empty,
    input  logic                   pop,
    output logic [7:0]             out_byte,
    output logic                   out_last,
    // configuration writes
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    cfg_t   cfg_reg, cfg_next;
    logic   accept;
    logic   q_push;
    entry_t q_entry;
    logic   q_full;
    logic   q_pop;
    logic   q_head_valid;
    entry_t q_head;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (cfg_index)
                REG_CRC_ENABLE: cfg_next.crc_enable = cfg_data[0];
                REG_XOR_ENABLE: cfg_next.xor_enable = cfg_data[0];
                REG_XOR_KEY:    cfg_next.xor_key    = cfg_data;
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.crc_enable <= 1'b1;
            cfg_reg.xor_enable <= 1'b0;
            cfg_reg.xor_key    <= '0;
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

    // input beat accept
    assign full   = q_full;
    assign accept = push && !q_full;

    crcxf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .cfg       (cfg_reg),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    crcxf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    crcxf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

    // a packet's final beat is always followed by the next packet's header
    `CRCXF_ASSERT_NEXT(a_hdr_after_last, pop && !empty && out_last, empty || (out_byte == NONCE_TEXT[0]))
    // a waiting command fills a free output register in the next cycle
    `CRCXF_ASSERT_NEXT(a_out_fill, q_head_valid && empty, !empty)
    // an input beat into an idle block shows up via queue and output register
    `CRCXF_ASSERT_LATER(a_idle_latency, push && !full && !q_head_valid && empty, !empty)

endmodule
